@@ rtl/core/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// srs_pkg
// Types, constants and helpers shared by the sequence read summary block.
// ----------------------------------------------------------------------------
package srs_pkg;

	// Saturation limit of the position and of every counter
	localparam longint unsigned MAX_LEN = 64'd65535;
	localparam int CNT_W = $clog2(MAX_LEN + 64'd1);

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int SYM_W = 8;
	localparam int FIG_W = 16;

	localparam logic [SYM_W-1:0] CHAR_A = 8'h41;
	localparam logic [SYM_W-1:0] CHAR_C = 8'h43;
	localparam logic [SYM_W-1:0] CHAR_G = 8'h47;
	localparam logic [SYM_W-1:0] CHAR_T = 8'h54;
	localparam logic [SYM_W-1:0] CHAR_N = 8'h4E;

	localparam logic [SYM_W-1:0] GAP_FIRST_RST  = 8'h2D;
	localparam logic [SYM_W-1:0] GAP_SECOND_RST = 8'h2E;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_GAP_FIRST  = 1'b0,
		CFG_GAP_SECOND = 1'b1
	} cfg_index_t;

	typedef logic [CNT_W-1:0] cnt_t;
	localparam cnt_t MAX_CNT = CNT_W'(MAX_LEN);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             has_symbol;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [FIG_W-1:0] start_pos;
		logic [FIG_W-1:0] end_pos;
		logic [FIG_W-1:0] base_count;
		logic [FIG_W-1:0] ambiguous_count;
		logic [FIG_W-1:0] longest_run;
		logic [FIG_W-1:0] n_count;
	} result_t;

	// Classified word passed from front to back
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             has_symbol;
		logic             last;
		logic             is_gap;
		logic             is_acgt;
		logic             is_n;
	} class_word_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		cnt_t r;
		if (v >= MAX_CNT) begin
			r = MAX_CNT;
		end else begin
			r = v + cnt_t'(1);
		end
		return r;
	endfunction

	function automatic logic [FIG_W-1:0] to_fig(input cnt_t v);
		return FIG_W'(v);
	endfunction

endpackage

@@ rtl/core/srs_front.sv @@
// ----------------------------------------------------------------------------
// srs_front
// Holds the gap characters, accepts items and classifies each character.
// ----------------------------------------------------------------------------
module srs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                item_valid,
	output logic                item_stall,
	input  srs_pkg::item_t      item,
	input  logic                queue_full,
	output logic                push,
	output srs_pkg::class_word_t push_word
);
	import srs_pkg::*;

	logic [SYM_W-1:0] gap_first_q;
	logic [SYM_W-1:0] gap_second_q;
	cfg_index_t       cfg_sel;

	assign cfg_sel = cfg_index_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_first_q  <= GAP_FIRST_RST;
			gap_second_q <= GAP_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				CFG_GAP_FIRST:  gap_first_q  <= cfg_data;
				CFG_GAP_SECOND: gap_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	always_comb begin
		push_word.symbol     = item.symbol;
		push_word.has_symbol = item.has_symbol;
		push_word.last       = item.last;
		push_word.is_gap     = (item.symbol == gap_first_q) || (item.symbol == gap_second_q);
		push_word.is_acgt    = (item.symbol == CHAR_A) || (item.symbol == CHAR_C) ||
		                       (item.symbol == CHAR_G) || (item.symbol == CHAR_T);
		push_word.is_n       = (item.symbol == CHAR_N);
	end

endmodule

@@ rtl/core/srs_queue.sv @@
// ----------------------------------------------------------------------------
// srs_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module srs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  srs_pkg::class_word_t push_word,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output srs_pkg::class_word_t pop_word
);
	import srs_pkg::*;

	class_word_t       entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_word  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ rtl/core/srs_back.sv @@
// ----------------------------------------------------------------------------
// srs_back
// Keeps the running counters and registers the summary on the last word.
// ----------------------------------------------------------------------------
module srs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 not_empty,
	input  srs_pkg::class_word_t pop_word,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output srs_pkg::result_t     result
);
	import srs_pkg::*;

	cnt_t             pos_q, first_pos_q, last_pos_q, bases_q, amb_q, n_q, run_q, best_q;
	logic             first_seen_q;
	logic [SYM_W-1:0] prev_q;

	cnt_t             pos_d, first_pos_d, last_pos_d, bases_d, amb_d, n_d, run_d, best_d;
	logic             first_seen_d;
	logic [SYM_W-1:0] prev_d;

	logic             out_free;
	logic             result_valid_q;
	result_t          result_q;
	result_t          summary;

	// A non-last word never waits on the output register
	assign out_free = !result_valid_q || !result_stall;
	assign pop      = not_empty && (!pop_word.last || out_free);

	always_comb begin
		pos_d        = pos_q;
		first_seen_d = first_seen_q;
		first_pos_d  = first_pos_q;
		last_pos_d   = last_pos_q;
		bases_d      = bases_q;
		amb_d        = amb_q;
		n_d          = n_q;
		prev_d       = prev_q;
		run_d        = run_q;
		best_d       = best_q;
		if (pop_word.has_symbol) begin
			pos_d = sat_inc(pos_q);
			if (!pop_word.is_gap) begin
				if (!first_seen_q) begin
					first_seen_d = 1'b1;
					first_pos_d  = pos_d;
				end
				last_pos_d = pos_d;
				if (bases_q != '0 && pop_word.symbol == prev_q) begin
					run_d = sat_inc(run_q);
				end else begin
					run_d = cnt_t'(1);
				end
				if (run_d > best_q) begin
					best_d = run_d;
				end
				prev_d  = pop_word.symbol;
				bases_d = sat_inc(bases_q);
				if (!pop_word.is_acgt) begin
					amb_d = sat_inc(amb_q);
				end
				if (pop_word.is_n) begin
					n_d = sat_inc(n_q);
				end
			end
		end

		if (pos_d == '0) begin
			summary.start_pos = '0;
			summary.end_pos   = '0;
		end else if (!first_seen_d) begin
			summary.start_pos = FIG_W'(1);
			summary.end_pos   = FIG_W'(1);
		end else begin
			summary.start_pos = to_fig(first_pos_d);
			summary.end_pos   = to_fig(last_pos_d);
		end
		summary.base_count      = to_fig(bases_d);
		summary.ambiguous_count = to_fig(amb_d);
		summary.longest_run     = to_fig(best_d);
		summary.n_count         = to_fig(n_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			first_seen_q <= 1'b0;
			first_pos_q  <= '0;
			last_pos_q   <= '0;
			bases_q      <= '0;
			amb_q        <= '0;
			n_q          <= '0;
			prev_q       <= '0;
			run_q        <= '0;
			best_q       <= '0;
		end else if (pop) begin
			if (pop_word.last) begin
				// drop the per-sequence state once the summary is taken
				pos_q        <= '0;
				first_seen_q <= 1'b0;
				first_pos_q  <= '0;
				last_pos_q   <= '0;
				bases_q      <= '0;
				amb_q        <= '0;
				n_q          <= '0;
				prev_q       <= '0;
				run_q        <= '0;
				best_q       <= '0;
			end else begin
				pos_q        <= pos_d;
				first_seen_q <= first_seen_d;
				first_pos_q  <= first_pos_d;
				last_pos_q   <= last_pos_d;
				bases_q      <= bases_d;
				amb_q        <= amb_d;
				n_q          <= n_d;
				prev_q       <= prev_d;
				run_q        <= run_d;
				best_q       <= best_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop && pop_word.last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_word.last) begin
			result_q <= summary;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_first_seen_bases: assert property (@(posedge clk) disable iff (!arst_n)
		first_seen_q == (bases_q != '0))
		else $error("first non-gap flag out of step with base count");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= amb_q) && (amb_q <= bases_q))
		else $error("N or ambiguous count exceeds base count");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q <= best_q) && (best_q <= bases_q))
		else $error("run length exceeds base count");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |-> !(pop && pop_word.last))
		else $error("summary overwritten while waiting");

endmodule

@@ rtl/core/sequence_read_summary.sv @@
// ----------------------------------------------------------------------------
// sequence_read_summary
// Running summary of an aligned nucleotide sequence, one character a word.
// ----------------------------------------------------------------------------
// Takes one character word per clock cycle. A word with last set yields one
// summary word; the last word is registered in the queue and is then taken
// straight into the result register once that register is free, which drives
// the result port. A four-word queue separates the classifying front from the
// counter back, so the input keeps flowing while a summary waits on a stalled
// result port; the input stalls only when that queue is full. Counters
// saturate at the package limit and no clearing pass follows reset. Write the
// gap characters only while no sequence is in flight.
module sequence_read_summary (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  srs_pkg::item_t     item,
	output logic               result_valid,
	input  logic               result_stall,
	output srs_pkg::result_t   result
);
	import srs_pkg::*;

	logic        push;
	logic        pop;
	logic        queue_full;
	logic        not_empty;
	class_word_t push_word;
	class_word_t pop_word;

	srs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_word  (push_word)
	);

	srs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_word  (pop_word)
	);

	srs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (not_empty),
		.pop_word     (pop_word),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ tb/sv/sequence_read_summary_chk.sv @@
// ----------------------------------------------------------------------------
// sequence_read_summary_chk
// Watches both channels of the read summary block and checks every summary.
// ----------------------------------------------------------------------------
// Keeps its own copy of the gap registers from the write port. For every word
// accepted on the input side it updates the per-sequence tallies. Each word
// marked last queues one expected summary. Summaries accepted on the result
// side are compared field by field, in order.
`timescale 1ns / 1ps

module sequence_read_summary_chk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic             item_valid,
	input  logic             item_stall,
	input  srs_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  srs_pkg::result_t result,
	output int               errors,
	output int               outstanding
);
	import srs_pkg::*;

	localparam longint unsigned SAT_LIMIT = MAX_LEN;

	logic [SYM_W-1:0] gap_first;
	logic [SYM_W-1:0] gap_second;

	longint unsigned  pos_cnt;
	bit               seen_base;
	longint unsigned  first_base_pos;
	longint unsigned  last_base_pos;
	longint unsigned  base_tally;
	longint unsigned  ambig_tally;
	longint unsigned  n_tally;
	logic [SYM_W-1:0] prev_sym;
	longint unsigned  run_len;
	longint unsigned  best_run_len;

	result_t summary_q[$];
	int      fail_tally;

	function automatic longint unsigned bump(input longint unsigned v);
		return (v >= SAT_LIMIT) ? SAT_LIMIT : v + 64'd1;
	endfunction

	task automatic clear_tally();
		pos_cnt        = 0;
		seen_base      = 1'b0;
		first_base_pos = 0;
		last_base_pos  = 0;
		base_tally     = 0;
		ambig_tally    = 0;
		n_tally        = 0;
		prev_sym       = '0;
		run_len        = 0;
		best_run_len   = 0;
	endtask

	task automatic take_word(input item_t w);
		result_t s;
		logic    is_gap;
		logic    is_acgt;
		is_gap  = (w.symbol == gap_first) || (w.symbol == gap_second);
		is_acgt = (w.symbol == CHAR_A) || (w.symbol == CHAR_C) ||
			(w.symbol == CHAR_G) || (w.symbol == CHAR_T);
		if (w.has_symbol) begin
			pos_cnt = bump(pos_cnt);
			if (!is_gap) begin
				if (!seen_base) begin
					seen_base      = 1'b1;
					first_base_pos = pos_cnt;
				end
				last_base_pos = pos_cnt;
				// gaps are skipped, so they never break a run
				if (base_tally != 0 && w.symbol == prev_sym) begin
					run_len = bump(run_len);
				end else begin
					run_len = 1;
				end
				if (run_len > best_run_len) begin
					best_run_len = run_len;
				end
				prev_sym   = w.symbol;
				base_tally = bump(base_tally);
				if (!is_acgt) begin
					ambig_tally = bump(ambig_tally);
				end
				if (w.symbol == CHAR_N) begin
					n_tally = bump(n_tally);
				end
			end
		end
		if (w.last) begin
			if (pos_cnt == 0) begin
				s.start_pos = '0;
				s.end_pos   = '0;
			end else if (!seen_base) begin
				s.start_pos = FIG_W'(1);
				s.end_pos   = FIG_W'(1);
			end else begin
				s.start_pos = FIG_W'(first_base_pos);
				s.end_pos   = FIG_W'(last_base_pos);
			end
			s.base_count      = FIG_W'(base_tally);
			s.ambiguous_count = FIG_W'(ambig_tally);
			s.longest_run     = FIG_W'(best_run_len);
			s.n_count         = FIG_W'(n_tally);
			summary_q = {summary_q, s};
			clear_tally();
		end
	endtask

	task automatic check_field(input string name, input logic [FIG_W-1:0] want,
		input logic [FIG_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			gap_first  = GAP_FIRST_RST;
			gap_second = GAP_SECOND_RST;
			clear_tally();
			summary_q.delete();
			fail_tally = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_GAP_FIRST) begin
					gap_first = cfg_data;
				end else begin
					gap_second = cfg_data;
				end
			end
			if (item_valid && !item_stall) begin
				take_word(item);
			end
			if (result_valid && !result_stall) begin
				if (summary_q.size() == 0) begin
					$display("%0t: summary word with none expected, expected nothing, actual %h",
						$time, result);
					fail_tally++;
				end else begin
					want = summary_q.pop_front();
					check_field("start_pos", want.start_pos, result.start_pos);
					check_field("end_pos", want.end_pos, result.end_pos);
					check_field("base_count", want.base_count, result.base_count);
					check_field("ambiguous_count", want.ambiguous_count,
						result.ambiguous_count);
					check_field("longest_run", want.longest_run, result.longest_run);
					check_field("n_count", want.n_count, result.n_count);
				end
			end
			errors      <= fail_tally;
			outstanding <= summary_q.size();
		end
	end

endmodule

@@ tb/sv/sequence_read_summary_tb.sv @@
// ----------------------------------------------------------------------------
// sequence_read_summary_tb
// Stimulus and verdict for the sequence read summary block.
// ----------------------------------------------------------------------------
// Drives a directed set of sequences (empty, all gaps, closes without a
// character, gap registers holding N and the byte extremes), then random
// sequences under several gap settings. Both sides idle at random, with one
// phase free of idling. The checker beside the block does all comparison.
`timescale 1ns / 1ps

module sequence_read_summary_tb;
	import srs_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;

	int         errors;
	int         outstanding;
	bit         calm = 1'b0;
	int         words_sent;
	logic [7:0] gap_a;
	logic [7:0] gap_b;

	sequence_read_summary dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	sequence_read_summary_chk u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(40_000_000);
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 26);
	end

	function automatic item_t mk(input logic [7:0] sym, input logic has, input logic lst);
		item_t w;
		w.symbol     = sym;
		w.has_symbol = has;
		w.last       = lst;
		return w;
	endfunction

	// Hold the word until it is taken; idle first at random
	task automatic send_word(input item_t w);
		while (!calm && $urandom_range(0, 99) < 26) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_text(input string s, input bit close_empty);
		for (int i = 0; i < s.len(); i++) begin
			send_word(mk(s[i], 1'b1, !close_empty && (i == s.len() - 1)));
		end
		if (close_empty) begin
			send_word(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
		end
	endtask

	// Drop valid, wait for every summary, then let the pipeline empty
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_gaps(input logic [7:0] g1, input logic [7:0] g2);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_GAP_FIRST;
		cfg_data  <= g1;
		@(posedge clk);
		cfg_index <= CFG_GAP_SECOND;
		cfg_data  <= g2;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		gap_a = g1;
		gap_b = g2;
	endtask

	function automatic logic [7:0] pick_symbol(input logic [7:0] prev);
		int r;
		logic [7:0] bases [4];
		bases = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};
		r = $urandom_range(0, 99);
		if (r < 25) begin
			return prev;
		end else if (r < 68) begin
			return bases[$urandom_range(0, 3)];
		end else if (r < 76) begin
			return CHAR_N;
		end else if (r < 88) begin
			return $urandom_range(0, 1) ? gap_a : gap_b;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed sequences, some empty closes and ignored words
	task automatic random_phase(input int words);
		int         kind;
		int         len;
		bit         close_empty;
		logic [7:0] sym;
		int         stop_at;
		stop_at = words_sent + words;
		while (words_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				send_word(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
			end else if (kind < 10) begin
				send_word(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
				words_sent--;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
					: $urandom_range(1, 16);
				close_empty = ($urandom_range(0, 99) < 15);
				sym = pick_symbol(CHAR_A);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 3) begin
						send_word(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
						words_sent--;
					end
					send_word(mk(sym, 1'b1, !close_empty && (i == len - 1)));
					sym = pick_symbol(sym);
				end
				if (close_empty) begin
					send_word(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
				end
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_GAP_FIRST;
		cfg_data   <= '0;
		item_valid <= 1'b0;
		item       <= '0;
		words_sent = 0;
		gap_a      = GAP_FIRST_RST;
		gap_b      = GAP_SECOND_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gap characters
		send_word(mk(8'h00, 1'b0, 1'b1));
		send_word(mk(8'hFF, 1'b0, 1'b0));
		send_text("ACGT", 1'b0);
		send_text("-.-", 1'b0);
		send_text("--", 1'b1);
		send_text("AA-A.NNa", 1'b0);
		send_word(mk(8'h00, 1'b1, 1'b0));
		send_word(mk(8'h00, 1'b1, 1'b0));
		send_word(mk(8'hFF, 1'b1, 1'b1));
		settle();

		// N as a gap
		write_gaps(CHAR_N, 8'hFF);
		send_text("NAN", 1'b0);
		send_word(mk(8'hFF, 1'b1, 1'b1));
		send_text("-.N", 1'b1);
		settle();

		write_gaps(8'h00, 8'h00);
		send_word(mk(8'h00, 1'b1, 1'b0));
		send_text("C-", 1'b0);
		settle();

		write_gaps(8'hFF, CHAR_A);
		send_text("AACGG", 1'b0);
		settle();

		random_phase(225);
		settle();
		write_gaps(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_phase(225);
		settle();
		calm = 1'b1;
		write_gaps(CHAR_N, GAP_FIRST_RST);
		random_phase(225);
		settle();
		calm = 1'b0;
		write_gaps(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_phase(225);
		settle();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
